### rtl/rpwa_pkg.sv
// ----------------------------------------------------------------------------
// rpwa_pkg: RC pulse width to angle shared definitions
// Field widths, register indexes and fixed-point constants of the decoder.
// ----------------------------------------------------------------------------
package rpwa_pkg;

    localparam int TICK_BITS = 32;
    localparam logic [31:0] TICK_MASK = 32'((33'd1 << TICK_BITS) - 33'd1);

    localparam int S_TDATA_W = 32;  // edge_tick
    localparam int M_TDATA_W = 56;  // pulse_width, percent, angle
    localparam int CFG_IDX_W = 8;
    localparam int CFG_DAT_W = 16;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_RANGE_LOW   = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_RANGE_HIGH  = 8'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ANGLE_LOWER = 8'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ANGLE_UPPER = 8'd3;

    localparam logic [15:0] RANGE_LOW_RST   = 16'd1000;
    localparam logic [15:0] RANGE_HIGH_RST  = 16'd2000;
    localparam logic [15:0] ANGLE_LOWER_RST = 16'hFF4C;  // -180
    localparam logic [15:0] ANGLE_UPPER_RST = 16'd180;

    // |num * 100| < 2^39
    localparam int DIV_BITS = 39;
    localparam logic [5:0] DIV_LAST = 6'(DIV_BITS - 1);

    localparam logic signed [40:0] PCT_SCALE = 41'sd100;
    // x / 10 == (x * 52429) >> 19 for x below 2^18
    localparam logic [15:0] RECIP_10 = 16'd52429;
    localparam int RECIP_SHIFT = 19;
    localparam logic signed [15:0] ANGLE_OFFSET = 16'sd180;

endpackage

### rtl/rc_pulse_width_to_angle_unit.sv
// ----------------------------------------------------------------------------
// rc_pulse_width_to_angle_unit: RC servo pulse width decoder
// Turns edge events of an RC PWM line into width, percent and angle.
// ----------------------------------------------------------------------------
// Usage:
//   s_ channel: one transfer per line edge; s_tuser[0] is the new level,
//   s_tdata the free-running tick. A rising edge only stores its tick and
//   leaves s_tready high. A falling edge starts a run of a restoring
//   divider, one quotient bit per cycle, between a prepare step and the
//   percent, angle, rounding and output steps; the result then shows on
//   the m_ channel, and s_tready stays low until the result is loaded into
//   the output register. With an empty range the divider is skipped and
//   the prepare step goes straight on to the percent step.
//   Throughput: a new falling edge is taken only once the last result is
//   loaded; one rising edge per cycle while idle.
//   m_ channel: result held in an output register; while the receiver
//   stalls, the next item is still taken, and a new result waits in the
//   last sequencer step until the output register is free.
//   cfg_ channel: always ready; write only while the unit is idle.
//   Reset (aresetn low, synchronous): registers return to their defaults,
//   the stored rising tick to zero, and no result is pending.
// ----------------------------------------------------------------------------
module rc_pulse_width_to_angle_unit (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [rpwa_pkg::S_TDATA_W-1:0]    s_tdata,   // [31:0] edge_tick
    input  logic [0:0]                        s_tuser,   // [0] edge_level
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // [31:0] pulse_width, [39:32] percent, [55:40] angle
    output logic [rpwa_pkg::M_TDATA_W-1:0]    m_tdata,
    output logic [0:0]                        m_tuser,   // [0] range_error
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [rpwa_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [rpwa_pkg::CFG_DAT_W-1:0]    cfg_data
);

    typedef enum logic [6:0] {
        ST_IDLE = 7'b0000001,
        ST_PREP = 7'b0000010,
        ST_DIV  = 7'b0000100,
        ST_PCT  = 7'b0001000,
        ST_ANG  = 7'b0010000,
        ST_RND  = 7'b0100000,
        ST_OUT  = 7'b1000000
    } state_t;

    state_t state_reg, state_next;

    logic [15:0] range_low_reg, range_low_next;
    logic [15:0] range_high_reg, range_high_next;
    logic [15:0] angle_lower_reg, angle_lower_next;
    logic [15:0] angle_upper_reg, angle_upper_next;
    logic [31:0] rise_tick_reg, rise_tick_next;

    logic [31:0] width_reg, width_next;
    logic [rpwa_pkg::DIV_BITS-1:0] dvd_reg, dvd_next;
    logic [15:0] rem_reg, rem_next;
    logic [15:0] den_mag_reg, den_mag_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic        neg_reg, neg_next;
    logic        err_reg, err_next;
    logic [7:0]  pct_reg, pct_next;
    logic [12:0] rnd_in_reg, rnd_in_next;
    logic [15:0] angle_reg, angle_next;

    logic                           m_tvalid_reg, m_tvalid_next;
    logic [rpwa_pkg::M_TDATA_W-1:0] m_tdata_reg, m_tdata_next;
    logic                           m_tuser_reg, m_tuser_next;

    logic signed [33:0] num;
    logic signed [40:0] prod;
    logic [40:0]        prod_mag;
    logic signed [16:0] den;
    logic [16:0]        den_mag;
    logic [16:0]        trial;
    logic               trial_ge;
    logic [16:0]        trial_diff;
    logic [7:0]         pct_abs;
    logic [28:0]        prod10;
    logic [9:0]         q10;
    logic signed [15:0] rnd;
    logic signed [15:0] clamp_lo;
    logic signed [15:0] clamp_hi;
    logic               out_free;
    logic               s_xfer;

    assign s_tready  = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_tdata_reg;
    assign m_tuser   = m_tuser_reg;

    assign s_xfer   = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;

    // datapath terms
    assign num      = $signed({2'b00, width_reg}) - $signed({18'd0, range_low_reg});
    assign prod     = $signed({{7{num[33]}}, num}) * rpwa_pkg::PCT_SCALE;
    assign prod_mag = prod[40] ? 41'(-prod) : 41'(prod);
    assign den      = $signed({1'b0, range_high_reg}) - $signed({1'b0, range_low_reg});
    assign den_mag  = den[16] ? 17'(-den) : 17'(den);

    assign trial      = {rem_reg, dvd_reg[rpwa_pkg::DIV_BITS-1]};
    assign trial_ge   = (trial >= {1'b0, den_mag_reg});
    assign trial_diff = trial - {1'b0, den_mag_reg};

    assign pct_abs = pct_reg[7] ? 8'(-pct_reg) : pct_reg;
    assign prod10  = 29'(rnd_in_reg) * 29'(rpwa_pkg::RECIP_10);
    assign q10     = prod10[28:rpwa_pkg::RECIP_SHIFT];
    assign rnd     = neg_reg ? -$signed({6'd0, q10}) : $signed({6'd0, q10});

    assign clamp_lo = ($signed(angle_reg) < $signed(angle_lower_reg)) ?
                      $signed(angle_lower_reg) : $signed(angle_reg);
    assign clamp_hi = (clamp_lo > $signed(angle_upper_reg)) ?
                      $signed(angle_upper_reg) : clamp_lo;

    always_comb begin
        state_next       = state_reg;
        range_low_next   = range_low_reg;
        range_high_next  = range_high_reg;
        angle_lower_next = angle_lower_reg;
        angle_upper_next = angle_upper_reg;
        rise_tick_next   = rise_tick_reg;
        width_next       = width_reg;
        dvd_next         = dvd_reg;
        rem_next         = rem_reg;
        den_mag_next     = den_mag_reg;
        cnt_next         = cnt_reg;
        neg_next         = neg_reg;
        err_next         = err_reg;
        pct_next         = pct_reg;
        rnd_in_next      = rnd_in_reg;
        angle_next       = angle_reg;
        m_tvalid_next    = m_tvalid_reg && !m_tready;
        m_tdata_next     = m_tdata_reg;
        m_tuser_next     = m_tuser_reg;

        if (cfg_valid) begin
            unique case (cfg_index)
                rpwa_pkg::REG_RANGE_LOW:   range_low_next   = cfg_data;
                rpwa_pkg::REG_RANGE_HIGH:  range_high_next  = cfg_data;
                rpwa_pkg::REG_ANGLE_LOWER: angle_lower_next = cfg_data;
                rpwa_pkg::REG_ANGLE_UPPER: angle_upper_next = cfg_data;
                default: ;
            endcase
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (s_xfer) begin
                    if (s_tuser[0]) begin
                        rise_tick_next = s_tdata & rpwa_pkg::TICK_MASK;
                    end else begin
                        width_next = ((s_tdata & rpwa_pkg::TICK_MASK) - rise_tick_reg)
                                     & rpwa_pkg::TICK_MASK;
                        state_next = ST_PREP;
                    end
                end
            end
            ST_PREP: begin
                dvd_next     = prod_mag[rpwa_pkg::DIV_BITS-1:0];
                rem_next     = '0;
                den_mag_next = den_mag[15:0];
                neg_next     = prod[40] ^ den[16];
                err_next     = (den == 17'sd0);
                cnt_next     = rpwa_pkg::DIV_LAST;
                state_next   = (den == 17'sd0) ? ST_PCT : ST_DIV;
            end
            ST_DIV: begin
                rem_next = trial_ge ? trial_diff[15:0] : trial[15:0];
                dvd_next = {dvd_reg[rpwa_pkg::DIV_BITS-2:0], trial_ge};
                cnt_next = cnt_reg - 6'd1;
                if (cnt_reg == 6'd0) begin
                    state_next = ST_PCT;
                end
            end
            ST_PCT: begin
                if (err_reg) begin
                    pct_next = 8'd0;
                end else if (neg_reg) begin
                    pct_next = (dvd_reg > 39'd128) ? 8'h80 : 8'(-dvd_reg[7:0]);
                end else begin
                    pct_next = (dvd_reg > 39'd127) ? 8'h7F : dvd_reg[7:0];
                end
                state_next = ST_ANG;
            end
            ST_ANG: begin
                // |36 * pct| + 5 for rounding half away from zero
                rnd_in_next = ({5'd0, pct_abs} << 5) + ({5'd0, pct_abs} << 2) + 13'd5;
                neg_next    = pct_reg[7];
                state_next  = ST_RND;
            end
            ST_RND: begin
                angle_next = rnd - rpwa_pkg::ANGLE_OFFSET;
                state_next = ST_OUT;
            end
            ST_OUT: begin
                if (out_free) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {clamp_hi, pct_reg, width_reg};
                    m_tuser_next  = err_reg;
                    state_next    = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_IDLE;
            range_low_reg   <= rpwa_pkg::RANGE_LOW_RST;
            range_high_reg  <= rpwa_pkg::RANGE_HIGH_RST;
            angle_lower_reg <= rpwa_pkg::ANGLE_LOWER_RST;
            angle_upper_reg <= rpwa_pkg::ANGLE_UPPER_RST;
            rise_tick_reg   <= '0;
            m_tvalid_reg    <= 1'b0;
            cnt_reg         <= '0;
        end else begin
            state_reg       <= state_next;
            range_low_reg   <= range_low_next;
            range_high_reg  <= range_high_next;
            angle_lower_reg <= angle_lower_next;
            angle_upper_reg <= angle_upper_next;
            rise_tick_reg   <= rise_tick_next;
            m_tvalid_reg    <= m_tvalid_next;
            cnt_reg         <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        width_reg   <= width_next;
        dvd_reg     <= dvd_next;
        rem_reg     <= rem_next;
        den_mag_reg <= den_mag_next;
        neg_reg     <= neg_next;
        err_reg     <= err_next;
        pct_reg     <= pct_next;
        rnd_in_reg  <= rnd_in_next;
        angle_reg   <= angle_next;
        m_tdata_reg <= m_tdata_next;
        m_tuser_reg <= m_tuser_next;
    end

endmodule

### rtl/rpwa_checker.sv
// ----------------------------------------------------------------------------
// rpwa_checker: port-level checks for the pulse width decoder
// Watches the stream ports and flags handshake and sequencing slips.
// ----------------------------------------------------------------------------
module rpwa_checker (
    input logic                           aclk,
    input logic                           aresetn,
    input logic                           s_tvalid,
    input logic                           s_tready,
    input logic [0:0]                     s_tuser,
    input logic                           m_tvalid,
    input logic                           m_tready,
    input logic [rpwa_pkg::M_TDATA_W-1:0] m_tdata,
    input logic [0:0]                     m_tuser
);

    // stalled result holds
    a_m_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    // empty range forces zero percent
    a_err_pct: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[0] |-> m_tdata[39:32] == 8'd0)
        else $error("range error with nonzero percent");

    // falling edge transfer drops ready while the result is computed
    a_fall_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && !s_tuser[0] |=> !s_tready)
        else $error("ready after falling edge transfer");

    // rising edge transfer only stores the tick
    a_rise_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && s_tuser[0] |=> s_tready)
        else $error("not ready after rising edge transfer");

endmodule

bind rc_pulse_width_to_angle_unit rpwa_checker u_rpwa_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
